// ----- rtl/core/sha1_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 hash core.
package sha1_pkg;

    localparam int unsigned ROUND_W = 7;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [ROUND_W-1:0] SCHED_ROUNDS = 7'd16;

    localparam logic [31:0] SHA1_IV0 = 32'h67452301;
    localparam logic [31:0] SHA1_IV1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA1_IV2 = 32'h98BADCFE;
    localparam logic [31:0] SHA1_IV3 = 32'h10325476;
    localparam logic [31:0] SHA1_IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] SHA1_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  bytes_valid;
        logic        last_word;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_h0;
        logic [31:0] digest_h1;
        logic [31:0] digest_h2;
        logic [31:0] digest_h3;
        logic [31:0] digest_h4;
    } sha1_out_t;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic init;     // load working vars from the chaining value
        logic step;     // run one round
        logic fold;     // add working vars into the chaining value
        logic iv_load;  // restore the initial chaining value
    } sha1_round_ctrl_t;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic load;     // shift in a message word
        logic step;     // shift in the schedule word of the current round
        logic early;    // current round is one of the first sixteen
    } sha1_sched_ctrl_t;

    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = SHA1_K0;
        end else if (rnd < 7'd40) begin
            k = SHA1_K1;
        end else if (rnd < 7'd60) begin
            k = SHA1_K2;
        end else begin
            k = SHA1_K3;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [ROUND_W-1:0] rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ----- rtl/core/sha1_sched.sv -----
// Message block buffer and 16-word schedule window as one shift line.
module sha1_sched
    import sha1_pkg::*;
(
    input  logic             aclk,
    input  sha1_sched_ctrl_t ctrl,
    input  logic [31:0]      load_word,
    output logic [31:0]      w_word
);

    logic [31:0] win_reg [16];
    logic [31:0] mix;

    // win_reg[0] holds W[t-16], win_reg[15] holds W[t-1]
    assign mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_word = ctrl.early ? win_reg[0] : {mix[30:0], mix[31]};

    always_ff @(posedge aclk) begin
        if (ctrl.load || ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= ctrl.load ? load_word : w_word;
        end
    end

endmodule

// ----- rtl/core/sha1_round.sv -----
// SHA-1 round unit: working variables, chaining value and the shared round adder.
module sha1_round
    import sha1_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  sha1_round_ctrl_t   ctrl,
    input  logic [ROUND_W-1:0] rnd,
    input  logic [31:0]        w_word,
    output sha1_out_t          chain
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic [31:0] temp;

    assign temp = {a_reg[26:0], a_reg[31:27]} + round_f(rnd, b_reg, c_reg, d_reg)
                + e_reg + w_word + round_k(rnd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
        end else if (ctrl.init) begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
            e_reg <= h4_reg;
        end else if (ctrl.step) begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.iv_load) begin
            h0_reg <= SHA1_IV0;
            h1_reg <= SHA1_IV1;
            h2_reg <= SHA1_IV2;
            h3_reg <= SHA1_IV3;
            h4_reg <= SHA1_IV4;
        end else if (ctrl.fold) begin
            h0_reg <= h0_reg + a_reg;
            h1_reg <= h1_reg + b_reg;
            h2_reg <= h2_reg + c_reg;
            h3_reg <= h3_reg + d_reg;
            h4_reg <= h4_reg + e_reg;
        end
    end

    assign chain.digest_h0 = h0_reg;
    assign chain.digest_h1 = h1_reg;
    assign chain.digest_h2 = h2_reg;
    assign chain.digest_h3 = h3_reg;
    assign chain.digest_h4 = h4_reg;

endmodule

// ----- rtl/core/sha1_hash_core.sv -----
// A word that completes a block starts a compression: init, 80 rounds at one per cycle
// in the shared round adder, then fold.
// A last word adds padding, one or two compressions and a handoff of the digest.
// Input words are not accepted while a 64-byte block is padded or compressed.
// Reset: synchronous, active low; restores the initial chaining value and clears
// the length, fill position and result valid. Buffer contents are not cleared.
module sha1_hash_core
    import sha1_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sha1_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sha1_out_t m_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PAD    = 4'd1;
    localparam logic [3:0] ST_ZERO   = 4'd2;
    localparam logic [3:0] ST_LEN_HI = 4'd3;
    localparam logic [3:0] ST_LEN_LO = 4'd4;
    localparam logic [3:0] ST_CINIT  = 4'd5;
    localparam logic [3:0] ST_COMP   = 4'd6;
    localparam logic [3:0] ST_FOLD   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [3:0]         post_reg, post_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [3:0]         word_index_reg, word_index_next;
    logic [1:0]         lane_reg, lane_next;
    logic [31:0]        acc_reg, acc_next;
    logic [63:0]        bit_length_reg, bit_length_next;
    logic               m_valid_reg;
    sha1_out_t          m_data_reg;

    logic               accept;
    logic               out_free;
    logic [2:0]         nb;
    logic [2:0]         total;
    logic [31:0]        data_masked;
    logic [63:0]        merged;
    logic               push_en;
    logic [31:0]        push_word;
    sha1_round_ctrl_t   round_ctrl;
    sha1_sched_ctrl_t   sched_ctrl;
    logic [31:0]        w_word;
    sha1_out_t          chain_value;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // byte packing: append the leading valid bytes behind the partial word
    assign nb          = (s_data.bytes_valid > 3'd4) ? 3'd4 : s_data.bytes_valid;
    assign data_masked = s_data.data_word & ~(32'hFFFFFFFF >> {nb, 3'b000});
    assign merged      = {acc_reg, 32'h0} | ({data_masked, 32'h0} >> {lane_reg, 3'b000});
    assign total       = {1'b0, lane_reg} + nb;

    always_comb begin
        state_next      = state_reg;
        post_next       = post_reg;
        round_next      = round_reg;
        word_index_next = word_index_reg;
        lane_next       = lane_reg;
        acc_next        = acc_reg;
        bit_length_next = bit_length_reg;
        push_en         = 1'b0;
        push_word       = '0;
        round_ctrl      = '0;
        sched_ctrl      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bit_length_next = bit_length_reg + {58'h0, nb, 3'b000};
                    lane_next       = total[1:0];
                    if (total[2]) begin
                        push_en   = 1'b1;
                        push_word = merged[63:32];
                        acc_next  = merged[31:0];
                    end else begin
                        acc_next = merged[63:32];
                    end
                    if (total[2] && word_index_reg == 4'd15) begin
                        state_next = ST_CINIT;
                        post_next  = s_data.last_word ? ST_PAD : ST_IDLE;
                    end else if (s_data.last_word) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // marker byte right behind the message, rest of the word zero
                push_en    = 1'b1;
                push_word  = acc_reg | (32'h80000000 >> {lane_reg, 3'b000});
                acc_next   = '0;
                lane_next  = '0;
                if (word_index_reg == 4'd15) begin
                    state_next = ST_CINIT;
                    post_next  = ST_ZERO;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (word_index_reg == 4'd14) begin
                    state_next = ST_LEN_HI;
                end else begin
                    push_en = 1'b1;
                    if (word_index_reg == 4'd15) begin
                        state_next = ST_CINIT;
                        post_next  = ST_ZERO;
                    end
                end
            end
            ST_LEN_HI: begin
                push_en    = 1'b1;
                push_word  = bit_length_reg[63:32];
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                push_en    = 1'b1;
                push_word  = bit_length_reg[31:0];
                state_next = ST_CINIT;
                post_next  = ST_DONE;
            end
            ST_CINIT: begin
                round_ctrl.init = 1'b1;
                round_next      = '0;
                state_next      = ST_COMP;
            end
            ST_COMP: begin
                round_ctrl.step  = 1'b1;
                sched_ctrl.step  = 1'b1;
                sched_ctrl.early = (round_reg < SCHED_ROUNDS);
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_FOLD: begin
                round_ctrl.fold = 1'b1;
                state_next      = post_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    round_ctrl.iv_load = 1'b1;
                    bit_length_next    = '0;
                    word_index_next    = '0;
                    lane_next          = '0;
                    acc_next           = '0;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        sched_ctrl.load = push_en;
        if (push_en) begin
            word_index_next = word_index_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            post_reg       <= ST_IDLE;
            round_reg      <= '0;
            word_index_reg <= '0;
            lane_reg       <= '0;
            acc_reg        <= '0;
            bit_length_reg <= '0;
        end else begin
            state_reg      <= state_next;
            post_reg       <= post_next;
            round_reg      <= round_next;
            word_index_reg <= word_index_next;
            lane_reg       <= lane_next;
            acc_reg        <= acc_next;
            bit_length_reg <= bit_length_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= chain_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    sha1_sched u_sched (
        .aclk      (aclk),
        .ctrl      (sched_ctrl),
        .load_word (push_word),
        .w_word    (w_word)
    );

    sha1_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (round_ctrl),
        .rnd     (round_reg),
        .w_word  (w_word),
        .chain   (chain_value)
    );

    // a new result only comes out of the finish state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result valid raised outside finish state");

    // compression only starts on a block boundary
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CINIT || state_reg == ST_COMP) |-> word_index_reg == 4'd0)
        else $error("compression started with a partial block");

    // rounds advance by one per cycle while compressing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && round_reg != LAST_ROUND) |=>
            (state_reg == ST_COMP && round_reg == $past(round_reg) + 7'd1))
        else $error("round counter skipped");

    // chaining value is back at its initial value after a digest is handed off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
            (chain_value.digest_h0 == SHA1_IV0 && chain_value.digest_h1 == SHA1_IV1 &&
             chain_value.digest_h2 == SHA1_IV2 && chain_value.digest_h3 == SHA1_IV3 &&
             chain_value.digest_h4 == SHA1_IV4))
        else $error("chaining value not restored after digest");

endmodule
